// ===== sv/bdq_pkg.sv =====
// Shared types and codes for the bounded deque with erase.
// No dependencies; used by the top level.
package bdq_pkg;

    localparam int unsigned REQ_W   = 3;
    localparam int unsigned FIELD_W = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned CNT_W   = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ_FRONT = 3'd4,
        REQ_READ_BACK  = 3'd5,
        REQ_ERASE      = 3'd6,
        REQ_CLEAR      = 3'd7
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_RESP
    } state_t;

endpackage

// ===== sv/bounded_deque_with_erase_top.sv =====
// Bounded double-ended queue of handle words with erase by value.
// Depends on bdq_pkg and bdq_mem.
//
// Holds up to DEPTH handles in a circular RAM with a front pointer and a count.
// One request is taken at a time. Push, pop, read and clear pass through the
// response state and offer their result from the result register once it is
// free; the next request is taken after that. Erase walks the RAM one entry per
// cycle from the front, then moves each later entry down one place per cycle.
// Its result is offered when the search ends with no match, or after the shift
// when the handle is found. The single RAM read port sets this pace. Handles
// keep their low HANDLE_W bits (at most 32), and entry_count reports the count
// after the request, low 5 bits.
module bounded_deque_with_erase_top #(
    parameter int unsigned DEPTH    = 16,
    parameter int unsigned HANDLE_W = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bdq_pkg::REQ_W-1:0]      s_req_type,
    input  logic [bdq_pkg::FIELD_W-1:0]    s_handle_in,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bdq_pkg::FIELD_W-1:0]    m_handle_out,
    output logic [bdq_pkg::STAT_W-1:0]     m_status,
    output logic [bdq_pkg::CNT_W-1:0]      m_entry_count
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = (HANDLE_W < bdq_pkg::FIELD_W) ? HANDLE_W : bdq_pkg::FIELD_W;
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    bdq_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]    front_reg, front_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [SW-1:0]    h_reg, h_next;
    bdq_pkg::status_t stat_reg, stat_next;
    logic             use_rd_reg, use_rd_next;

    logic                          m_valid_reg, m_valid_next;
    logic [bdq_pkg::FIELD_W-1:0]   m_handle_reg, m_handle_next;
    logic [bdq_pkg::STAT_W-1:0]    m_status_reg, m_status_next;
    logic [bdq_pkg::CNT_W-1:0]     m_count_reg, m_count_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [SW-1:0] wr_data, rd_data;

    logic [AW-1:0] front_m1, front_p1;
    logic          empty, full;
    bdq_pkg::req_t req;

    function automatic logic [AW-1:0] wrap(input logic [CW:0] sum);
        logic [CW:0] r;
        r = sum;
        if (r >= DEPTH_S) begin
            r = r - DEPTH_S;
        end
        if (r >= DEPTH_S) begin
            r = r - DEPTH_S;
        end
        return r[AW-1:0];
    endfunction

    bdq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (SW),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req      = bdq_pkg::req_t'(s_req_type);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == DEPTH_C);
    assign front_m1 = (front_reg == '0) ? LAST_A : front_reg - AW'(1);
    assign front_p1 = (front_reg == LAST_A) ? '0 : front_reg + AW'(1);

    assign s_ready       = (state_reg == bdq_pkg::S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_handle_out  = m_handle_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bdq_pkg::S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        h_reg        <= h_next;
        stat_reg     <= stat_next;
        use_rd_reg   <= use_rd_next;
        m_handle_reg <= m_handle_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    always_comb begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        h_next        = h_reg;
        stat_next     = stat_reg;
        use_rd_next   = use_rd_reg;
        m_valid_next  = m_valid_reg;
        m_handle_next = m_handle_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        wr_en         = 1'b0;
        wr_addr       = front_reg;
        wr_data       = s_handle_in[SW-1:0];
        rd_en         = 1'b0;
        rd_addr       = front_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            bdq_pkg::S_IDLE: begin
                if (s_valid) begin
                    h_next      = s_handle_in[SW-1:0];
                    stat_next   = bdq_pkg::ST_OK;
                    use_rd_next = 1'b0;
                    k_next      = '0;
                    state_next  = bdq_pkg::S_RESP;
                    case (req)
                        bdq_pkg::REQ_PUSH_FRONT: begin
                            if (full) begin
                                stat_next = bdq_pkg::ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = front_m1;
                                front_next = front_m1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bdq_pkg::REQ_PUSH_BACK: begin
                            if (full) begin
                                stat_next = bdq_pkg::ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = wrap((CW + 1)'(front_reg) + (CW + 1)'(count_reg));
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_READ_FRONT: begin
                            if (empty) begin
                                stat_next = bdq_pkg::ST_EMPTY;
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = front_reg;
                                use_rd_next = 1'b1;
                                if (req == bdq_pkg::REQ_POP_FRONT) begin
                                    front_next = front_p1;
                                    count_next = count_reg - CW'(1);
                                end
                            end
                        end
                        bdq_pkg::REQ_POP_BACK, bdq_pkg::REQ_READ_BACK: begin
                            if (empty) begin
                                stat_next = bdq_pkg::ST_EMPTY;
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = wrap((CW + 1)'(front_reg) + (CW + 1)'(count_reg)
                                                   - (CW + 1)'(1));
                                use_rd_next = 1'b1;
                                if (req == bdq_pkg::REQ_POP_BACK) begin
                                    count_next = count_reg - CW'(1);
                                end
                            end
                        end
                        bdq_pkg::REQ_ERASE: begin
                            if (empty) begin
                                stat_next = bdq_pkg::ST_NOTFOUND;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = front_reg;
                                state_next = bdq_pkg::S_SEARCH;
                            end
                        end
                        default: begin
                            front_next = '0;
                            count_next = '0;
                        end
                    endcase
                end
            end

            bdq_pkg::S_SEARCH: begin
                rd_en   = 1'b1;
                rd_addr = wrap((CW + 1)'(front_reg) + (CW + 1)'(k_reg) + (CW + 1)'(1));
                if (rd_data == h_reg) begin
                    state_next = bdq_pkg::S_SHIFT;
                end else if ((CW + 1)'(k_reg) + (CW + 1)'(1) < (CW + 1)'(count_reg)) begin
                    k_next = k_reg + CW'(1);
                end else begin
                    stat_next  = bdq_pkg::ST_NOTFOUND;
                    state_next = bdq_pkg::S_RESP;
                end
            end

            bdq_pkg::S_SHIFT: begin
                rd_en   = 1'b1;
                rd_addr = wrap((CW + 1)'(front_reg) + (CW + 1)'(k_reg) + (CW + 1)'(2));
                if ((CW + 1)'(k_reg) + (CW + 1)'(1) < (CW + 1)'(count_reg)) begin
                    wr_en   = 1'b1;
                    wr_addr = wrap((CW + 1)'(front_reg) + (CW + 1)'(k_reg));
                    wr_data = rd_data;
                    k_next  = k_reg + CW'(1);
                end else begin
                    count_next = count_reg - CW'(1);
                    stat_next  = bdq_pkg::ST_OK;
                    state_next = bdq_pkg::S_RESP;
                end
            end

            bdq_pkg::S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_handle_next = use_rd_reg ? bdq_pkg::FIELD_W'(rd_data) : '0;
                    m_status_next = stat_reg;
                    m_count_next  = bdq_pkg::CNT_W'(count_reg);
                    state_next    = bdq_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = bdq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/bdq_mem.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies; holds the deque entries for the top level.
module bdq_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
